// File: hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Widths of the fixed-point datapath, result codes and the records that
// travel between the front end, the square root pipe and the divider pipe.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COEF_W    = 32;
   localparam int NB_W      = COEF_W + 1;          // -b as signed
   localparam int PROD_W    = 2 * COEF_W;
   localparam int DISC_W    = PROD_W + 2;          // b*b + 4ac
   localparam int ROOT_W    = DISC_W / 2;
   localparam int REM_W     = ROOT_W + 3;
   localparam int NUM_W     = ROOT_W + 2;          // |-b +/- s|
   localparam int SUM_W     = NUM_W + 1;
   localparam int DEN_W     = COEF_W + 1;          // 2|a|
   localparam int DVD_W     = NUM_W + FRAC_BITS;

   typedef enum logic [1:0] {
      KIND_TWO_REAL = 2'd0,
      KIND_DOUBLE   = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_DEGEN    = 2'd3
   } root_kind_type;

   typedef struct packed {
      logic                     degen;
      logic                     a_neg;
      logic [COEF_W-1:0]        a_mag;
      logic signed [NB_W-1:0]   nb;
   } qrs_side_type;

   typedef struct packed {
      qrs_side_type             side;
      logic                     dneg;
      logic [DISC_W-1:0]        disc;
   } qrs_disc_type;

   typedef struct packed {
      qrs_side_type             side;
      logic                     dneg;
      logic [ROOT_W-1:0]        root;
   } qrs_root_type;

   typedef struct packed {
      root_kind_type            kind;
      logic                     neg1;
      logic                     neg2;
      logic                     use2;
   } qrs_tag_type;

endpackage

// File: hdl/qrs_req_if.sv
// ----------------------------------------------------------------------------
// qrs_req_if: coefficient channel
// Valid/ready channel carrying one set of Q coefficients per beat.
// ----------------------------------------------------------------------------
interface qrs_req_if;
   import qrs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_a;
   logic signed [COEF_W-1:0] coef_b;
   logic signed [COEF_W-1:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: hdl/qrs_rsp_if.sv
// ----------------------------------------------------------------------------
// qrs_rsp_if: result channel
// Valid/ready channel carrying the root kind, both roots and the clip flag.
// ----------------------------------------------------------------------------
interface qrs_rsp_if;
   import qrs_pkg::*;

   logic                     valid;
   logic                     ready;
   root_kind_type            root_kind;
   logic signed [COEF_W-1:0] root_first;
   logic signed [COEF_W-1:0] root_second;
   logic                     saturated;

   modport source (output valid, root_kind, root_first, root_second, saturated,
                   input ready);
   modport sink   (input valid, root_kind, root_first, root_second, saturated,
                   output ready);
endinterface

// File: hdl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: magnitudes, products and discriminant
// Three stages: sign split, the two 32x32 products, then b*b +/- 4ac.
// ----------------------------------------------------------------------------
module qrs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
   output logic                             out_valid,
   output qrs_pkg::qrs_disc_type            out_disc
);
   import qrs_pkg::*;

   // stage 0
   logic              v0_ff;
   qrs_side_type      side0_ff, side0_in;
   logic [COEF_W-1:0] bmag0_ff, bmag0_in, cmag0_ff, cmag0_in;
   logic              cneg0_ff, czero0_ff;
   // stage 1
   logic              v1_ff;
   qrs_side_type      side1_ff;
   logic [PROD_W-1:0] bb1_ff, bb1_in, ac1_ff, ac1_in;
   logic              cneg1_ff, czero1_ff;
   // stage 2
   logic              v2_ff;
   qrs_disc_type      disc2_ff, disc2_in;

   logic [DISC_W-1:0] bb_w, ac4_w;

   always_comb begin
      side0_in.degen = (coef_a == '0);
      side0_in.a_neg = coef_a[COEF_W-1];
      side0_in.a_mag = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
      side0_in.nb    = NB_W'(0) - {coef_b[COEF_W-1], coef_b};
      bmag0_in       = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
      cmag0_in       = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;
   end

   always_comb begin
      bb1_in = bmag0_ff * bmag0_ff;
      ac1_in = side0_ff.a_mag * cmag0_ff;
   end

   always_comb begin
      bb_w  = {2'b00, bb1_ff};
      ac4_w = {ac1_ff, 2'b00};
      disc2_in.side = side1_ff;
      if ((side1_ff.a_neg != cneg1_ff) || czero1_ff) begin
         disc2_in.disc = bb_w + ac4_w;
         disc2_in.dneg = 1'b0;
      end else if (bb_w >= ac4_w) begin
         disc2_in.disc = bb_w - ac4_w;
         disc2_in.dneg = 1'b0;
      end else begin
         disc2_in.disc = ac4_w - bb_w;
         disc2_in.dneg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff  <= side0_in;
         bmag0_ff  <= bmag0_in;
         cmag0_ff  <= cmag0_in;
         cneg0_ff  <= coef_c[COEF_W-1];
         czero0_ff <= (coef_c == '0);
         side1_ff  <= side0_ff;
         bb1_ff    <= bb1_in;
         ac1_ff    <= ac1_in;
         cneg1_ff  <= cneg0_ff;
         czero1_ff <= czero0_ff;
         disc2_ff  <= disc2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_disc  = disc2_ff;
endmodule

// File: hdl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit with a running remainder.
// ----------------------------------------------------------------------------
module qrs_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  qrs_pkg::qrs_disc_type in_disc,
   output logic                  out_valid,
   output qrs_pkg::qrs_root_type out_root
);
   import qrs_pkg::*;

   typedef struct packed {
      qrs_side_type      side;
      logic              dneg;
      logic [DISC_W-1:0] d;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   logic   vld_ff [ROOT_W];
   sq_type st_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic             vprev;
      sq_type           prev, st_in;
      logic [REM_W-1:0] r, trial;

      if (i == 0) begin : g_first
         assign vprev     = in_valid;
         assign prev.side = in_disc.side;
         assign prev.dneg = in_disc.dneg;
         assign prev.d    = in_disc.disc;
         assign prev.rem  = '0;
         assign prev.root = '0;
      end else begin : g_next
         assign vprev = vld_ff[i-1];
         assign prev  = st_ff[i-1];
      end

      always_comb begin
         r     = {prev.rem[REM_W-3:0], prev.d[DISC_W-1 -: 2]};
         trial = REM_W'({prev.root, 2'b01});
         st_in = prev;
         st_in.d = {prev.d[DISC_W-3:0], 2'b00};
         if (r >= trial) begin
            st_in.rem  = r - trial;
            st_in.root = {prev.root[ROOT_W-2:0], 1'b1};
         end else begin
            st_in.rem  = r;
            st_in.root = {prev.root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vprev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= st_in;
         end
      end
   end

   assign out_valid     = vld_ff[ROOT_W-1];
   assign out_root.side = st_ff[ROOT_W-1].side;
   assign out_root.dneg = st_ff[ROOT_W-1].dneg;
   assign out_root.root = st_ff[ROOT_W-1].root;
endmodule

// File: hdl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: numerator setup and two-lane restoring divider pipe
// Forms both numerators, then one quotient bit per lane per stage.
// ----------------------------------------------------------------------------
module qrs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  qrs_pkg::qrs_root_type       in_root,
   output logic                        out_valid,
   output qrs_pkg::qrs_tag_type        out_tag,
   output logic [qrs_pkg::DVD_W-1:0]   out_quo1,
   output logic [qrs_pkg::DVD_W-1:0]   out_quo2
);
   import qrs_pkg::*;

   typedef struct packed {
      logic [DVD_W-1:0] dvd;
      logic [DEN_W-1:0] rem;
      logic [DVD_W-1:0] quo;
   } lane_type;

   function automatic lane_type div_step(lane_type p, logic [DEN_W-1:0] den);
      logic [DEN_W:0] t;
      lane_type       n;
      t     = {p.rem, p.dvd[DVD_W-1]};
      n     = p;
      n.dvd = {p.dvd[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
         n.rem = DEN_W'(t - {1'b0, den});
         n.quo = {p.quo[DVD_W-2:0], 1'b1};
      end else begin
         n.rem = t[DEN_W-1:0];
         n.quo = {p.quo[DVD_W-2:0], 1'b0};
      end
      return n;
   endfunction

   function automatic logic [NUM_W-1:0] mag(logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] u;
      u = v[SUM_W-1] ? (~v + 1'b1) : v;
      return u[NUM_W-1:0];
   endfunction

   // numerator stage
   logic                    hv_ff;
   qrs_tag_type             htag_ff, htag_in;
   logic [DEN_W-1:0]        hden_ff, hden_in;
   lane_type                hl1_ff, hl1_in, hl2_ff, hl2_in;
   logic signed [SUM_W-1:0] nb_w, s_w, p_w, m_w;

   always_comb begin
      nb_w = SUM_W'(in_root.side.nb);
      s_w  = SUM_W'({1'b0, in_root.root});
      p_w  = nb_w + s_w;
      m_w  = nb_w - s_w;
      hden_in = {in_root.side.a_mag, 1'b0};
      hl1_in  = '0;
      hl2_in  = '0;
      htag_in.neg2 = 1'b0;
      htag_in.use2 = 1'b1;
      htag_in.neg1 = nb_w[SUM_W-1] ^ in_root.side.a_neg;
      hl1_in.dvd   = {mag(nb_w), FRAC_BITS'(0)};
      if (in_root.side.degen) begin
         htag_in.kind = KIND_DEGEN;
      end else if (in_root.dneg) begin
         htag_in.kind = KIND_COMPLEX;
         hl2_in.dvd   = {mag(s_w), FRAC_BITS'(0)};
      end else if (in_root.root == '0) begin
         htag_in.kind = KIND_DOUBLE;
         htag_in.use2 = 1'b0;
      end else begin
         htag_in.kind = KIND_TWO_REAL;
         htag_in.neg1 = p_w[SUM_W-1] ^ in_root.side.a_neg;
         htag_in.neg2 = m_w[SUM_W-1] ^ in_root.side.a_neg;
         hl1_in.dvd   = {mag(p_w), FRAC_BITS'(0)};
         hl2_in.dvd   = {mag(m_w), FRAC_BITS'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
      end else if (en) begin
         hv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         htag_ff <= htag_in;
         hden_ff <= hden_in;
         hl1_ff  <= hl1_in;
         hl2_ff  <= hl2_in;
      end
   end

   // divider stages
   logic             vld_ff [DVD_W];
   qrs_tag_type      tag_ff [DVD_W];
   logic [DEN_W-1:0] den_ff [DVD_W];
   lane_type         l1_ff  [DVD_W];
   lane_type         l2_ff  [DVD_W];

   for (genvar i = 0; i < DVD_W; i++) begin : g_step
      logic             vprev;
      qrs_tag_type      tprev;
      logic [DEN_W-1:0] dprev;
      lane_type         l1prev, l2prev;

      if (i == 0) begin : g_first
         assign vprev  = hv_ff;
         assign tprev  = htag_ff;
         assign dprev  = hden_ff;
         assign l1prev = hl1_ff;
         assign l2prev = hl2_ff;
      end else begin : g_next
         assign vprev  = vld_ff[i-1];
         assign tprev  = tag_ff[i-1];
         assign dprev  = den_ff[i-1];
         assign l1prev = l1_ff[i-1];
         assign l2prev = l2_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vprev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[i] <= tprev;
            den_ff[i] <= dprev;
            l1_ff[i]  <= div_step(l1prev, dprev);
            l2_ff[i]  <= div_step(l2prev, dprev);
         end
      end
   end

   assign out_valid = vld_ff[DVD_W-1];
   assign out_tag   = tag_ff[DVD_W-1];
   assign out_quo1  = l1_ff[DVD_W-1].quo;
   assign out_quo2  = l2_ff[DVD_W-1].quo;
endmodule

// File: hdl/quadratic_root_solver_core.sv
// Path: front end, square root pipe, numerator register, divider pipe, result register.
// Throughput: one coefficient set per cycle; set by the one-bit-per-stage square root
// and divider pipes, all stages advance together while the result register is free.
// Reset: synchronous, active high; clears every stage valid and the result valid.
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: pipelined fixed-point quadratic root solver
// Discriminant, square root, two divisions and saturation in one stream.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core (
   input  logic     clock,
   input  logic     reset,
   qrs_req_if.sink  req_if,
   qrs_rsp_if.source rsp_if
);
   import qrs_pkg::*;

   typedef struct packed {
      logic [COEF_W-1:0] val;
      logic              sat;
   } clip_type;

   localparam logic [DVD_W-1:0] POS_MAX = DVD_W'({1'b0, {(COEF_W-1){1'b1}}});
   localparam logic [DVD_W-1:0] NEG_MAX = DVD_W'({1'b1, {(COEF_W-1){1'b0}}});

   function automatic clip_type clip(logic [DVD_W-1:0] q, logic neg);
      clip_type c;
      c.sat = 1'b0;
      if (neg && (q != '0)) begin
         if (q > NEG_MAX) begin
            c.sat = 1'b1;
            c.val = NEG_MAX[COEF_W-1:0];
         end else begin
            c.val = COEF_W'(0) - q[COEF_W-1:0];
         end
      end else if (q > POS_MAX) begin
         c.sat = 1'b1;
         c.val = POS_MAX[COEF_W-1:0];
      end else begin
         c.val = q[COEF_W-1:0];
      end
      return c;
   endfunction

   logic             en;
   logic             fv, sv, dv;
   qrs_disc_type     fdisc;
   qrs_root_type     sroot;
   qrs_tag_type      dtag;
   logic [DVD_W-1:0] dq1, dq2;
   clip_type         c1, c2;

   logic                     rv_ff;
   root_kind_type            kind_ff, kind_in;
   logic [COEF_W-1:0]        r1_ff, r1_in, r2_ff, r2_in;
   logic                     sat_ff, sat_in;

   // advance the whole pipe unless a finished beat is held
   assign en           = !rv_ff || rsp_if.ready;
   assign req_if.ready = en;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .coef_a    (req_if.coef_a),
      .coef_b    (req_if.coef_b),
      .coef_c    (req_if.coef_c),
      .out_valid (fv),
      .out_disc  (fdisc)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fv),
      .in_disc   (fdisc),
      .out_valid (sv),
      .out_root  (sroot)
   );

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_root   (sroot),
      .out_valid (dv),
      .out_tag   (dtag),
      .out_quo1  (dq1),
      .out_quo2  (dq2)
   );

   always_comb begin
      c1      = clip(dq1, dtag.neg1);
      c2      = clip(dq2, dtag.neg2);
      kind_in = dtag.kind;
      if (dtag.kind == KIND_DEGEN) begin
         r1_in  = '0;
         r2_in  = '0;
         sat_in = 1'b0;
      end else begin
         r1_in  = c1.val;
         r2_in  = dtag.use2 ? c2.val : '0;
         sat_in = c1.sat | (dtag.use2 & c2.sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind_in;
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_if.valid       = rv_ff;
   assign rsp_if.root_kind   = kind_ff;
   assign rsp_if.root_first  = r1_ff;
   assign rsp_if.root_second = r2_ff;
   assign rsp_if.saturated   = sat_ff;
endmodule
